>>> design/in_order_completion_buffer_assert.svh
`ifndef IN_ORDER_COMPLETION_BUFFER_ASSERT_SVH
`define IN_ORDER_COMPLETION_BUFFER_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define IOCB_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iocb assertion failed");

// next-cycle implication
`define IOCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iocb assertion failed");

`endif

>>> design/iocb_pkg.sv
package iocb_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 32;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_END   = 2'd1,
    MODE_DRAIN = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_RETIRED = 3'd0,
    KIND_PENDING = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_DUP     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_UPDATE = 2'd2,
    OP_SHIFT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_DRAIN = 2'd2
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              done;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } entry_t;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   key_id;
    logic [TIME_W-1:0] key_time;
  } cell_ctl_t;

  localparam entry_t EMPTY_ENTRY = '{valid: 1'b0, done: 1'b0, id: '0,
                                     start_time: '0, end_time: '0};

endpackage

>>> design/iocb_cell.sv
module iocb_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iocb_pkg::cell_ctl_t ctl_i,
  input  iocb_pkg::entry_t   prev_i,
  input  iocb_pkg::entry_t   next_i,
  input  logic               prev_gt_i,
  input  logic               prev_lt_i,
  output iocb_pkg::entry_t   entry_o,
  output logic               gt_o,
  output logic               lt_o,
  output logic               hit_o
);
  import iocb_pkg::*;

  logic              valid_q, valid_d;
  logic              done_q, done_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [TIME_W-1:0] end_q, end_d;
  entry_t            entry_q, entry_d;
  logic              open;

  assign entry_q = '{valid: valid_q, done: done_q, id: id_q,
                     start_time: start_q, end_time: end_q};
  assign entry_o = entry_q;

  assign gt_o  = valid_q && (start_q > ctl_i.key_time);
  assign lt_o  = valid_q && (start_q < ctl_i.key_time);
  assign hit_o = valid_q && ((id_q == ctl_i.key_id) || (start_q == ctl_i.key_time));
  assign open  = !valid_q || gt_o;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      OP_INSERT: begin
        if (prev_gt_i) begin
          entry_d = prev_i;
        end else if (prev_lt_i && open) begin
          entry_d = '{valid: 1'b1, done: 1'b0, id: ctl_i.key_id,
                      start_time: ctl_i.key_time, end_time: '0};
        end
      end
      OP_UPDATE: begin
        if (valid_q && (id_q == ctl_i.key_id)) begin
          entry_d.end_time = ctl_i.key_time;
          entry_d.done     = 1'b1;
        end
      end
      OP_SHIFT: begin
        entry_d = next_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  assign valid_d = entry_d.valid;
  assign done_d  = entry_d.done;
  assign id_d    = entry_d.id;
  assign start_d = entry_d.start_time;
  assign end_d   = entry_d.end_time;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    start_q <= start_d;
    end_q   <= end_d;
  end

endmodule

>>> design/in_order_completion_buffer.sv
// in_order_completion_buffer
// Holds up to DEPTH process entries sorted by start time in a row of cells.
// Input channel (in_valid_i/in_ready_o): mode_i, proc_id_i, time_value_i.
//   start inserts an entry (rejected if its id or start time is already held
//   or the row is full), end marks the entry with that id done, drain retires done entries from the head in order.
// Output channel (out_valid_o/out_ready_i): kind_o, out_id_o, out_start_o,
//   out_end_o, last_o; last_o marks the final word caused by an input word.
// Sequence: a start or end word is accepted, then compared across all cells
//   at once in the exec state; a rejected start loads its word into the output
//   register at the end of that compare, once the output register is free.
// In a drain the head cell is read and the row shifts by one cell per cycle,
//   one output word per cycle while the output register is free.
// in_ready_o is high only between words; a word may be accepted while the
//   previous result still waits in the output register.
// When the receiver stalls, a rejected start or a drain holds its word and
//   waits, with the cell row frozen, until the output register frees up.
// Reset clears all valid and done bits, the control state and out_valid_o;
//   the block is ready to accept a word as soon as reset is released.
module in_order_completion_buffer #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] proc_id_i,
  input  logic [31:0] time_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [15:0] out_id_o,
  output logic [31:0] out_start_o,
  output logic [31:0] out_end_o,
  output logic        last_o
);
  import iocb_pkg::*;

  `include "in_order_completion_buffer_assert.svh"

  state_e            state_q, state_d;
  mode_e             cmd_mode_q;
  logic [ID_W-1:0]   cmd_id_q;
  logic [TIME_W-1:0] cmd_time_q;

  cell_ctl_t         ctl;
  entry_t            entries [DEPTH];
  logic [DEPTH-1:0]  gt, lt, hit;
  logic              dup, full, out_free, in_fire;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  kind_e             out_kind_q, out_kind_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic [TIME_W-1:0] out_start_q, out_start_d;
  logic [TIME_W-1:0] out_end_q, out_end_d;
  logic              out_last_q, out_last_d;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_gt, prev_lt;
    if (i == 0) begin : g_head
      assign prev_e  = EMPTY_ENTRY;
      assign prev_gt = 1'b0;
      assign prev_lt = 1'b1;
    end else begin : g_body
      assign prev_e  = entries[i-1];
      assign prev_gt = gt[i-1];
      assign prev_lt = lt[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_e = EMPTY_ENTRY;
    end else begin : g_mid
      assign next_e = entries[i+1];
    end
    iocb_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .prev_i    (prev_e),
      .next_i    (next_e),
      .prev_gt_i (prev_gt),
      .prev_lt_i (prev_lt),
      .entry_o   (entries[i]),
      .gt_o      (gt[i]),
      .lt_o      (lt[i]),
      .hit_o     (hit[i])
    );
  end

  assign dup      = |hit;
  assign full     = entries[DEPTH-1].valid;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire  = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    ctl.op       = OP_HOLD;
    ctl.key_id   = cmd_id_q;
    ctl.key_time = cmd_time_q;
    out_load     = 1'b0;
    out_kind_d   = KIND_EMPTY;
    out_id_d     = '0;
    out_start_d  = '0;
    out_end_d    = '0;
    out_last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_e'(mode_i))
            MODE_START, MODE_END: state_d = S_EXEC;
            MODE_DRAIN:           state_d = S_DRAIN;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_EXEC: begin
        if (cmd_mode_q == MODE_START) begin
          if (dup || full) begin
            if (out_free) begin
              out_load   = 1'b1;
              out_kind_d = dup ? KIND_DUP : KIND_FULL;
              out_id_d   = cmd_id_q;
              state_d    = S_IDLE;
            end
          end else begin
            ctl.op  = OP_INSERT;
            state_d = S_IDLE;
          end
        end else begin
          ctl.op  = OP_UPDATE;
          state_d = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (entries[0].valid && entries[0].done) begin
            out_kind_d  = KIND_RETIRED;
            out_id_d    = entries[0].id;
            out_start_d = entries[0].start_time;
            out_end_d   = entries[0].end_time;
            out_last_d  = 1'b0;
            ctl.op      = OP_SHIFT;
          end else if (entries[0].valid) begin
            out_kind_d  = KIND_PENDING;
            out_id_d    = entries[0].id;
            out_start_d = entries[0].start_time;
            state_d     = S_IDLE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_mode_q <= mode_e'(mode_i);
      cmd_id_q   <= proc_id_i;
      cmd_time_q <= time_value_i;
    end
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_id_q    <= out_id_d;
      out_start_q <= out_start_d;
      out_end_q   <= out_end_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign out_id_o    = out_id_q;
  assign out_start_o = out_start_q;
  assign out_end_o   = out_end_q;
  assign last_o      = out_last_q;

  // entries stay packed toward the head and sorted by start time
  `IOCB_ASSERT(a_head_compact, entries[1].valid, entries[0].valid)
  `IOCB_ASSERT(a_head_sorted, entries[0].valid && entries[1].valid,
               entries[0].start_time < entries[1].start_time)
  `IOCB_ASSERT(a_no_insert_full, ctl.op == OP_INSERT, !full)
  `IOCB_ASSERT_NEXT(a_last_frees_input, out_load && out_last_d, in_ready_o)

endmodule
